### sv/multi_reader_frame_ring_macros.svh
// ----------------------------------------------------------------------------
// multi_reader_frame_ring assertion macros
// Shared concurrent assertion forms for the frame ring checkers.
// ----------------------------------------------------------------------------
`ifndef MULTI_READER_FRAME_RING_MACROS_SVH
`define MULTI_READER_FRAME_RING_MACROS_SVH

// same-cycle implication
`define MRFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame ring assertion failed");

// next-cycle implication
`define MRFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame ring assertion failed");

`endif

### sv/mrfr_pkg.sv
// ----------------------------------------------------------------------------
// mrfr_pkg
// Types, widths and codes shared by the frame ring modules.
// ----------------------------------------------------------------------------
package mrfr_pkg;

    localparam int READER_SLOTS = 8;
    localparam int DESC_DEPTH   = 64;
    localparam int SLOT_LIMIT   = (READER_SLOTS < 8) ? READER_SLOTS : 8;

    localparam int SLOT_W     = $clog2(READER_SLOTS);
    localparam int FRAME_W    = $clog2(DESC_DEPTH);
    localparam int RING_W     = FRAME_W + 1;
    localparam int NIDX_W     = $clog2(READER_SLOTS + 1);
    localparam int KBIT_W     = $clog2(FRAME_W);
    localparam int RS_W       = 3;
    localparam int KEY_W      = 32;
    localparam int TAG_W      = 32;
    localparam int LEN_W      = 21;
    localparam int PEND_W     = 6;
    localparam int CNT_W      = 3;
    localparam int ALU_W      = 32;
    localparam int FSLOT_W    = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [LEN_W-1:0]  BUF_BYTES_RST = LEN_W'(1048576);
    localparam logic [RING_W-1:0] RING_N_RST    = RING_W'(DESC_DEPTH);

    typedef enum logic [2:0] {
        OP_PUT,
        OP_GET,
        OP_PEEK,
        OP_SKIP,
        OP_SYNC,
        OP_JOIN,
        OP_LEAVE
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY,
        ST_NO_READERS,
        ST_NO_SLOT
    } t_status;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_SLOTS,
        CFG_BUFFER_BYTES
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_EXEC,
        S_PUT_FIT,
        S_PUT_HEAD,
        S_READ,
        S_TAIL,
        S_JOIN_MATCH,
        S_JOIN_FREE,
        S_PEND,
        S_PEND_FIX,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]       operation;
        logic [RS_W-1:0]  reader_slot;
        logic [KEY_W-1:0] reader_key;
        logic [TAG_W-1:0] frame_tag;
        logic [LEN_W-1:0] frame_length;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [RS_W-1:0]   assigned_slot;
        logic [TAG_W-1:0]  tag_out;
        logic [LEN_W-1:0]  offset_out;
        logic [LEN_W-1:0]  length_out;
        logic [PEND_W-1:0] pending_count;
        logic [CNT_W-1:0]  reader_count;
    } t_resp;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] offset;
        logic [LEN_W-1:0] length;
    } t_desc;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_in;

    typedef struct packed {
        logic             carry;
        logic [ALU_W-1:0] sum;
    } t_alu_out;

endpackage

### sv/mrfr_alu.sv
// ----------------------------------------------------------------------------
// mrfr_alu
// Shared add/subtract unit; carry set on subtract means a >= b.
// ----------------------------------------------------------------------------
module mrfr_alu (
    input  mrfr_pkg::t_alu_in  i_op,
    output mrfr_pkg::t_alu_out o_res
);
    import mrfr_pkg::*;

    logic [ALU_W-1:0] w_b;
    logic [ALU_W:0]   w_sum;

    assign w_b   = i_op.sub ? ~i_op.b : i_op.b;
    assign w_sum = {1'b0, i_op.a} + {1'b0, w_b} + (ALU_W + 1)'(i_op.sub);
    assign o_res = w_sum;

endmodule

### sv/mrfr_desc_mem.sv
// ----------------------------------------------------------------------------
// mrfr_desc_mem
// Frame descriptor store, one port, registered read.
// ----------------------------------------------------------------------------
module mrfr_desc_mem (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [mrfr_pkg::FRAME_W-1:0]   i_addr,
    input  mrfr_pkg::t_desc                i_wdata,
    output mrfr_pkg::t_desc                o_rdata
);
    import mrfr_pkg::*;

    t_desc r_mem [DESC_DEPTH];
    t_desc r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/multi_reader_frame_ring.sv
// ----------------------------------------------------------------------------
// multi_reader_frame_ring
// Descriptor manager for a payload ring with one writer and several readers.
// ----------------------------------------------------------------------------
// Operations are taken one at a time: start is accepted when busy is low, and
// the result appears on o_resp with o_done high for one cycle, which the
// receiver must take then, as it cannot stall. A small sequencer steps every
// operation through one shared 32-bit add/subtract unit and a single-port
// descriptor memory with registered read. A put fits the frame into the
// buffer, writes its descriptor and advances the head; get reads a descriptor
// and advances the tail, peek only reads it and skip only advances it; join
// compares one reader slot per cycle until a key matches, else it takes a free
// slot. Every operation ends by computing the pending count. Writing
// frame_slots recomputes the working head and every working tail as the stored
// value modulo the new ring size, one bit of the quotient per cycle: busy stays
// high until that is done, and neither items nor further writes are taken.
module multi_reader_frame_ring (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mrfr_pkg::t_req                    i_req,
    output logic                              o_done,
    output mrfr_pkg::t_resp                   o_resp,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mrfr_pkg::CFG_ADDR_W-1:0]   i_cfg_index,
    input  logic [mrfr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mrfr_pkg::*;

    t_state r_state, n_state;
    t_req   r_req;
    t_resp  r_res, n_res;

    logic [FRAME_W-1:0] r_head, n_head;
    logic [FRAME_W-1:0] r_head_raw, n_head_raw;
    logic [LEN_W-1:0]   r_wofs, n_wofs;
    logic [CNT_W-1:0]   r_rcnt, n_rcnt;
    logic [FRAME_W-1:0] r_tail [READER_SLOTS];
    logic [FRAME_W-1:0] n_tail [READER_SLOTS];
    logic [FRAME_W-1:0] r_tail_raw [READER_SLOTS];
    logic [FRAME_W-1:0] n_tail_raw [READER_SLOTS];
    logic [KEY_W-1:0]   r_key  [READER_SLOTS];
    logic [KEY_W-1:0]   n_key  [READER_SLOTS];
    logic [READER_SLOTS-1:0] r_used, n_used;
    logic [RING_W-1:0]  r_ring_n, n_ring_n;
    logic [LEN_W-1:0]   r_buf_bytes, n_buf_bytes;

    logic [ALU_W-1:0]   r_acc, n_acc;
    logic [SLOT_W-1:0]  r_idx, n_idx;
    logic [SLOT_W-1:0]  r_pslot, n_pslot;
    logic [NIDX_W-1:0]  r_nidx, n_nidx;
    logic [KBIT_W-1:0]  r_kbit, n_kbit;
    logic [FRAME_W-1:0] r_nval, n_nval;

    t_alu_in  alu_in;
    t_alu_out alu_out;

    logic               mem_we;
    logic [FRAME_W-1:0] mem_addr;
    t_desc              mem_wdata;
    t_desc              mem_rdata;

    logic               cfg_fire;
    logic [FSLOT_W-1:0] cfg_fs;
    logic [SLOT_W-1:0]  rs;
    logic               rs_ok;
    logic               pslot_ok;
    logic [SLOT_W-1:0]  tail_raddr;
    logic [FRAME_W-1:0] tail_rd;
    logic [FRAME_W-1:0] norm_src;
    logic [FRAME_W-1:0] norm_a;
    logic [FRAME_W-1:0] norm_rem;
    logic [FRAME_W-1:0] inc_wrap;
    logic               free_found;
    logic [SLOT_W-1:0]  free_slot;
    logic               put_fit;
    logic [LEN_W-1:0]   put_ofs;

    mrfr_alu u_alu (
        .i_op  (alu_in),
        .o_res (alu_out)
    );

    mrfr_desc_mem u_desc_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_done      = (r_state == S_DONE);
    assign o_resp      = r_res;
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_fs      = i_cfg_data[FSLOT_W-1:0];

    assign rs       = SLOT_W'(r_req.reader_slot);
    assign rs_ok    = (r_req.reader_slot != '0) && (int'(r_req.reader_slot) < SLOT_LIMIT)
                      && r_used[rs];
    assign pslot_ok = (r_pslot != '0) && (int'(r_pslot) < SLOT_LIMIT) && r_used[r_pslot];

    // single tail read port
    always_comb begin
        unique case (r_state)
            S_PEND:  tail_raddr = r_pslot;
            default: tail_raddr = rs;
        endcase
    end
    assign tail_rd = r_tail[tail_raddr];

    // stored values are reduced, the working copies are overwritten
    assign norm_src = (r_nidx == NIDX_W'(READER_SLOTS)) ? r_head_raw
                                                        : r_tail_raw[r_nidx[SLOT_W-1:0]];
    assign norm_a   = (r_kbit == KBIT_W'(FRAME_W - 1)) ? norm_src : r_nval;
    assign norm_rem = alu_out.carry ? alu_out.sum[FRAME_W-1:0] : norm_a;
    assign inc_wrap = (alu_out.sum[RING_W-1:0] == r_ring_n) ? '0 : alu_out.sum[FRAME_W-1:0];
    assign put_fit  = alu_out.carry;
    assign put_ofs  = put_fit ? r_wofs : '0;

    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOT_LIMIT - 1; i >= 1; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_head      = r_head;
        n_head_raw  = r_head_raw;
        n_wofs      = r_wofs;
        n_rcnt      = r_rcnt;
        n_tail      = r_tail;
        n_tail_raw  = r_tail_raw;
        n_key       = r_key;
        n_used      = r_used;
        n_ring_n    = r_ring_n;
        n_buf_bytes = r_buf_bytes;
        n_acc       = r_acc;
        n_idx       = r_idx;
        n_pslot     = r_pslot;
        n_nidx      = r_nidx;
        n_kbit      = r_kbit;
        n_nval      = r_nval;
        alu_in      = '0;
        mem_we      = 1'b0;
        mem_addr    = r_head;
        mem_wdata   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (cfg_fire) begin
                    if (i_cfg_index == CFG_FRAME_SLOTS) begin
                        if (cfg_fs == '0) begin
                            n_ring_n = RING_W'(1);
                        end else if (int'(cfg_fs) > DESC_DEPTH) begin
                            n_ring_n = RING_W'(DESC_DEPTH);
                        end else begin
                            n_ring_n = RING_W'(cfg_fs);
                        end
                        n_nidx  = NIDX_W'(READER_SLOTS);
                        n_kbit  = KBIT_W'(FRAME_W - 1);
                        n_state = S_NORM;
                    end else if (i_cfg_index == CFG_BUFFER_BYTES) begin
                        n_buf_bytes = i_cfg_data[LEN_W-1:0];
                    end
                end else if (start) begin
                    n_state = S_EXEC;
                end
            end

            // restoring reduction of head and tails modulo the ring size
            S_NORM: begin
                alu_in.a   = ALU_W'(norm_a);
                alu_in.b   = ALU_W'(r_ring_n) << r_kbit;
                alu_in.sub = 1'b1;
                n_nval     = norm_rem;
                if (r_kbit == '0) begin
                    if (r_nidx == NIDX_W'(READER_SLOTS)) begin
                        n_head = norm_rem;
                    end else begin
                        n_tail[r_nidx[SLOT_W-1:0]] = norm_rem;
                    end
                    n_kbit = KBIT_W'(FRAME_W - 1);
                    if (r_nidx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_nidx = r_nidx - NIDX_W'(1);
                    end
                end else begin
                    n_kbit = r_kbit - KBIT_W'(1);
                end
            end

            S_EXEC: begin
                n_res        = '0;
                n_res.status = ST_OK;
                n_pslot      = rs;
                n_state      = S_PEND;
                unique case (r_req.operation)
                    OP_PUT: begin
                        if (r_rcnt == '0) begin
                            n_res.status = ST_NO_READERS;
                        end else begin
                            alu_in.a = ALU_W'(r_wofs);
                            alu_in.b = ALU_W'(r_req.frame_length);
                            n_acc    = alu_out.sum;
                            n_state  = S_PUT_FIT;
                        end
                    end
                    OP_GET, OP_PEEK, OP_SKIP: begin
                        if (!rs_ok || tail_rd == r_head) begin
                            if (r_req.operation != OP_SKIP) begin
                                n_res.status = ST_EMPTY;
                            end
                        end else if (r_req.operation == OP_SKIP) begin
                            n_state = S_TAIL;
                        end else begin
                            mem_addr = tail_rd;
                            n_state  = S_READ;
                        end
                    end
                    OP_SYNC: begin
                        if (rs_ok) begin
                            n_tail[rs]     = r_head;
                            n_tail_raw[rs] = r_head;
                        end
                    end
                    OP_JOIN: begin
                        n_pslot = '0;
                        n_idx   = SLOT_W'(1);
                        n_state = S_JOIN_MATCH;
                    end
                    OP_LEAVE: begin
                        if (rs_ok) begin
                            n_used[rs] = 1'b0;
                            n_key[rs]  = '0;
                            if (r_rcnt != '0) begin
                                n_rcnt = r_rcnt - CNT_W'(1);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_PUT_FIT: begin
                alu_in.a         = ALU_W'(r_buf_bytes);
                alu_in.b         = r_acc;
                alu_in.sub       = 1'b1;
                n_wofs           = put_fit ? r_acc[LEN_W-1:0] : r_req.frame_length;
                mem_we           = 1'b1;
                mem_wdata.tag    = r_req.frame_tag;
                mem_wdata.offset = put_ofs;
                mem_wdata.length = r_req.frame_length;
                n_res.tag_out    = r_req.frame_tag;
                n_res.offset_out = put_ofs;
                n_res.length_out = r_req.frame_length;
                n_state          = S_PUT_HEAD;
            end

            S_PUT_HEAD: begin
                alu_in.a   = ALU_W'(r_head);
                alu_in.b   = ALU_W'(1);
                n_head     = inc_wrap;
                n_head_raw = inc_wrap;
                n_state    = S_PEND;
            end

            S_READ: begin
                n_res.tag_out    = mem_rdata.tag;
                n_res.offset_out = mem_rdata.offset;
                n_res.length_out = mem_rdata.length;
                n_state          = (r_req.operation == OP_GET) ? S_TAIL : S_PEND;
            end

            S_TAIL: begin
                alu_in.a       = ALU_W'(tail_rd);
                alu_in.b       = ALU_W'(1);
                n_tail[rs]     = inc_wrap;
                n_tail_raw[rs] = inc_wrap;
                n_state        = S_PEND;
            end

            S_JOIN_MATCH: begin
                alu_in.a   = r_key[r_idx];
                alu_in.b   = r_req.reader_key;
                alu_in.sub = 1'b1;
                if (r_used[r_idx] && alu_out.sum == '0) begin
                    n_res.assigned_slot = RS_W'(r_idx);
                    n_pslot             = r_idx;
                    n_tail[r_idx]       = r_head;
                    n_tail_raw[r_idx]   = r_head;
                    n_state             = S_PEND;
                end else if (int'(r_idx) == SLOT_LIMIT - 1) begin
                    n_state = S_JOIN_FREE;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end

            S_JOIN_FREE: begin
                if (free_found) begin
                    n_used[free_slot]     = 1'b1;
                    n_key[free_slot]      = r_req.reader_key;
                    n_tail[free_slot]     = r_head;
                    n_tail_raw[free_slot] = r_head;
                    n_rcnt                = r_rcnt + CNT_W'(1);
                    n_res.assigned_slot   = RS_W'(free_slot);
                    n_pslot               = free_slot;
                end else begin
                    n_res.status = ST_NO_SLOT;
                end
                n_state = S_PEND;
            end

            S_PEND: begin
                n_res.reader_count = r_rcnt;
                if (!pslot_ok) begin
                    n_res.pending_count = '0;
                    n_state             = S_DONE;
                end else begin
                    alu_in.a   = ALU_W'(r_head);
                    alu_in.b   = ALU_W'(tail_rd);
                    alu_in.sub = 1'b1;
                    if (alu_out.carry) begin
                        n_res.pending_count = alu_out.sum[PEND_W-1:0];
                        n_state             = S_DONE;
                    end else begin
                        n_acc   = alu_out.sum;
                        n_state = S_PEND_FIX;
                    end
                end
            end

            S_PEND_FIX: begin
                alu_in.a            = r_acc;
                alu_in.b            = ALU_W'(r_ring_n);
                n_res.pending_count = alu_out.sum[PEND_W-1:0];
                n_state             = S_DONE;
            end

            S_DONE: begin
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_head_raw  <= '0;
            r_wofs      <= '0;
            r_rcnt      <= '0;
            r_used      <= '0;
            r_ring_n    <= RING_N_RST;
            r_buf_bytes <= BUF_BYTES_RST;
            for (int i = 0; i < READER_SLOTS; i++) begin
                r_tail[i]     <= '0;
                r_tail_raw[i] <= '0;
                r_key[i]      <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_head_raw  <= n_head_raw;
            r_wofs      <= n_wofs;
            r_rcnt      <= n_rcnt;
            r_used      <= n_used;
            r_ring_n    <= n_ring_n;
            r_buf_bytes <= n_buf_bytes;
            r_tail      <= n_tail;
            r_tail_raw  <= n_tail_raw;
            r_key       <= n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        r_res   <= n_res;
        r_acc   <= n_acc;
        r_idx   <= n_idx;
        r_pslot <= n_pslot;
        r_nidx  <= n_nidx;
        r_kbit  <= n_kbit;
        r_nval  <= n_nval;
    end

endmodule

### sv/mrfr_checker.sv
// ----------------------------------------------------------------------------
// mrfr_checker
// Port-level checks of the frame ring sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_reader_frame_ring_macros.svh"

module mrfr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic o_cfg_ready
);

    `MRFR_ASSERT_NXT(a_accept_goes_busy, i_clk, i_rst_n, start && !busy, busy)
    `MRFR_ASSERT_IMP(a_done_while_busy, i_clk, i_rst_n, o_done, busy)
    `MRFR_ASSERT_NXT(a_done_then_idle, i_clk, i_rst_n, o_done, !busy && !o_done)
    `MRFR_ASSERT_IMP(a_no_cfg_when_busy, i_clk, i_rst_n, busy, !o_cfg_ready)

endmodule

bind multi_reader_frame_ring mrfr_checker u_mrfr_checker (.*);
